// ===== hw/rtl/cantx_pkg.sv =====
// Shared types, character codes and helper functions for the CAN text
// command to transmit-buffer byte converter. No dependencies.
package cantx_pkg;

  // Largest number of data bytes a frame may carry.
  localparam int unsigned MAX_DATA_BYTES = 8;
  // Bytes of a transmit buffer ahead of the data: SIDH, SIDL, EID8, EID0, DLC.
  localparam int unsigned HEADER_BYTES = 5;
  localparam int unsigned FRAME_BYTES = HEADER_BYTES + MAX_DATA_BYTES;

  // Character codes used by the parser.
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_EIGHT = 8'h38;
  localparam logic [7:0] CHAR_UP_R  = 8'h52;
  localparam logic [7:0] CHAR_LOW_R = 8'h72;
  localparam logic [7:0] CHAR_UP_X  = 8'h58;
  localparam logic [7:0] CHAR_LOW_X = 8'h78;

  // Frame field constants.
  localparam logic [31:0] STD_ID_MAX  = 32'h0000_07FF;
  localparam logic [7:0]  RTR_FLAG    = 8'h40;

  // Result of decoding one hexadecimal digit.
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // One complete frame handed from the parser to the byte sender.
  typedef struct packed {
    logic [FRAME_BYTES-1:0][7:0] bytes;
    logic [3:0]                  count;
  } frame_t;

  // Decode a hexadecimal digit of either case.
  function automatic hex_t hex_val(input logic [7:0] c);
    hex_t r;
    r.ok  = 1'b0;
    r.val = 4'd0;
    if (c inside {["0":"9"]}) begin
      r.ok  = 1'b1;
      r.val = c[3:0];
    end else if (c inside {["a":"f"], ["A":"F"]}) begin
      r.ok  = 1'b1;
      r.val = 4'(c[3:0] + 4'd9);
    end
    return r;
  endfunction

  // White space as the C library sees it.
  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c inside {[8'd9:8'd13]});
  endfunction

  // Value of a two-character data pair under base-16 strtol rules.
  function automatic logic [7:0] pair_value(input logic [7:0] a, input logic [7:0] b);
    hex_t       ha;
    hex_t       hb;
    logic [7:0] r;
    ha = hex_val(a);
    hb = hex_val(b);
    r  = 8'd0;
    if (is_space(a) || (a == CHAR_PLUS)) begin
      r = hb.ok ? {4'd0, hb.val} : 8'd0;
    end else if (a == CHAR_MINUS) begin
      r = hb.ok ? 8'(8'd0 - {4'd0, hb.val}) : 8'd0;
    end else if (ha.ok) begin
      r = hb.ok ? {ha.val, hb.val} : {4'd0, ha.val};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/can_text_command_to_frame_bytes.sv =====
// Top level of the CAN text command to transmit-buffer byte converter.
// Instantiates cantx_parser and cantx_emitter; uses cantx_pkg.
//
// Input channel (item_valid/item_ready): one character of a command line
// "ID#DATA" or "ID#R<n>" per transaction, with line_end set on the last one.
// Output channel (byte_valid/byte_ready): the transmit buffer bytes SIDH,
// SIDL, EID8, EID0, DLC and the data bytes, each with its offset in
// byte_index and frame_last on the final byte of the frame.
// Throughput: one character per cycle, save where a line end waits (below).
// A character that ends a line is parsed in the cycle it is accepted and
// its frame is loaded into the output buffer, so the first byte appears in
// the next cycle; a frame holds 5 to 13 bytes, sent one per transaction.
// The output buffer holds one frame. While it still holds unsent bytes,
// characters that do not end a line keep being accepted, and a character
// that ends a line waits until the last byte is taken; it may be accepted
// in the same cycle as that last byte, so frames follow with no gap.
// When the receiver stalls, the current byte holds and the buffer waits.
// Reset clears the parse state, the held EID bytes and the output buffer;
// the block is ready to accept a character as soon as reset is released.
module can_text_command_to_frame_bytes (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] char_in,
  input  logic       line_end,
  input  logic       item_valid,
  output logic       item_ready,
  output logic [7:0] reg_byte,
  output logic [3:0] byte_index,
  output logic       frame_last,
  output logic       byte_valid,
  input  logic       byte_ready
);

  logic              accept;
  logic              frame_load;
  cantx_pkg::frame_t frame;

  // A line end needs the output buffer to be free or freeing in this cycle;
  // other characters always pass.
  assign item_ready = !byte_valid || !line_end || (byte_ready && frame_last);
  assign accept     = item_valid && item_ready;

  cantx_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .char_in    (char_in),
    .line_end   (line_end),
    .frame_load (frame_load),
    .frame      (frame)
  );

  cantx_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .load       (frame_load),
    .frame      (frame),
    .reg_byte   (reg_byte),
    .byte_index (byte_index),
    .frame_last (frame_last),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready)
  );

endmodule

// ===== hw/rtl/cantx_parser.sv =====
// Character parser: keeps the per-line parse state and, on the final
// character of a line, assembles a full transmit frame. Uses cantx_pkg.
module cantx_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        char_in,
  input  logic              line_end,
  output logic              frame_load,
  output cantx_pkg::frame_t frame
);

  // Parse phases.
  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_SIGNED = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_XSEEN  = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;
  localparam logic [2:0] PH_STOP   = 3'd5;
  localparam logic [2:0] PH_DATA   = 3'd6;
  localparam logic [2:0] PH_RWAIT  = 3'd7;

  localparam int unsigned IDX_W = $clog2(cantx_pkg::MAX_DATA_BYTES > 1 ?
                                         cantx_pkg::MAX_DATA_BYTES : 2);

  // Parse state registers.
  logic [2:0]  phase;
  logic [31:0] id_accum;
  logic        id_negative;
  logic [2:0]  prefix_len;
  logic [7:0]  pair_first;
  logic        pair_pending;
  logic [3:0]  data_count;
  logic        remote_flag;
  logic [3:0]  remote_len;
  logic        halted;
  logic [7:0]  held_eid_high;
  logic [7:0]  held_eid_low;
  logic [7:0]  data_store [cantx_pkg::MAX_DATA_BYTES];

  logic [2:0]  phase_next;
  logic [31:0] id_accum_next;
  logic        id_negative_next;
  logic [2:0]  prefix_len_next;
  logic [7:0]  pair_first_next;
  logic        pair_pending_next;
  logic [3:0]  data_count_next;
  logic        remote_flag_next;
  logic [3:0]  remote_len_next;
  logic        halted_next;

  logic             store_we;
  logic [7:0]       store_byte;
  cantx_pkg::hex_t  digit;
  logic [31:0]      id_shifted;

  // Frame assembly signals.
  logic        emit;
  logic        ext;
  logic [31:0] id;
  logic [7:0]  eid_high;
  logic [7:0]  eid_low;
  logic [7:0]  data_next [cantx_pkg::MAX_DATA_BYTES];

  assign digit      = cantx_pkg::hex_val(char_in);
  assign store_byte = cantx_pkg::pair_value(pair_first, char_in);
  // Identifier accumulation saturates once a digit would shift a nonzero top nibble out.
  assign id_shifted = (id_accum[31:28] != 4'd0) ? '1 : {id_accum[27:0], digit.val};

  // Next parse state for the character at the input.
  always_comb begin
    phase_next        = phase;
    id_accum_next     = id_accum;
    id_negative_next  = id_negative;
    prefix_len_next   = prefix_len;
    pair_first_next   = pair_first;
    pair_pending_next = pair_pending;
    data_count_next   = data_count;
    remote_flag_next  = remote_flag;
    remote_len_next   = remote_len;
    halted_next       = halted;
    store_we          = 1'b0;
    if (!halted) begin
      if (char_in == cantx_pkg::CHAR_NUL) begin
        halted_next = 1'b1;
      end else if (phase == PH_RWAIT) begin
        if (char_in inside {[cantx_pkg::CHAR_ZERO:cantx_pkg::CHAR_EIGHT]}) begin
          remote_len_next = char_in[3:0];
        end
        halted_next = 1'b1;
      end else if (phase == PH_DATA) begin
        if (!pair_pending && (data_count == 4'd0) &&
            ((char_in == cantx_pkg::CHAR_LOW_R) || (char_in == cantx_pkg::CHAR_UP_R))) begin
          remote_flag_next = 1'b1;
          phase_next       = PH_RWAIT;
        end else if (data_count < 4'(cantx_pkg::MAX_DATA_BYTES)) begin
          if (!pair_pending) begin
            pair_first_next   = char_in;
            pair_pending_next = 1'b1;
          end else begin
            store_we          = 1'b1;
            data_count_next   = data_count + 4'd1;
            pair_pending_next = 1'b0;
          end
        end
      end else if (char_in == cantx_pkg::CHAR_HASH) begin
        phase_next = PH_DATA;
      end else begin
        if (prefix_len < 3'd4) begin
          prefix_len_next = prefix_len + 3'd1;
        end
        case (phase)
          PH_LEAD: begin
            if (cantx_pkg::is_space(char_in)) begin
              phase_next = PH_LEAD;
            end else if ((char_in == cantx_pkg::CHAR_PLUS) ||
                         (char_in == cantx_pkg::CHAR_MINUS)) begin
              id_negative_next = (char_in == cantx_pkg::CHAR_MINUS);
              phase_next       = PH_SIGNED;
            end else if (char_in == cantx_pkg::CHAR_ZERO) begin
              phase_next = PH_ZERO;
            end else if (digit.ok) begin
              id_accum_next = id_shifted;
              phase_next    = PH_DIGITS;
            end else begin
              phase_next = PH_STOP;
            end
          end
          PH_SIGNED: begin
            if (char_in == cantx_pkg::CHAR_ZERO) begin
              phase_next = PH_ZERO;
            end else if (digit.ok) begin
              id_accum_next = id_shifted;
              phase_next    = PH_DIGITS;
            end else begin
              phase_next = PH_STOP;
            end
          end
          PH_ZERO: begin
            if ((char_in == cantx_pkg::CHAR_LOW_X) || (char_in == cantx_pkg::CHAR_UP_X)) begin
              phase_next = PH_XSEEN;
            end else if (digit.ok) begin
              id_accum_next = id_shifted;
              phase_next    = PH_DIGITS;
            end else begin
              phase_next = PH_STOP;
            end
          end
          PH_XSEEN, PH_DIGITS: begin
            if (digit.ok) begin
              id_accum_next = id_shifted;
              phase_next    = PH_DIGITS;
            end else begin
              phase_next = PH_STOP;
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end

  // Data bytes as they stand after this character.
  always_comb begin
    for (int k = 0; k < cantx_pkg::MAX_DATA_BYTES; k++) begin
      data_next[k] = (store_we && (data_count[IDX_W-1:0] == IDX_W'(k))) ?
                     store_byte : data_store[k];
    end
  end

  // Frame assembly from the state left by the final character.
  assign emit = accept && line_end && (phase_next >= PH_DATA) && (prefix_len_next != 3'd0);
  assign id   = id_negative_next ? (32'd0 - id_accum_next) : id_accum_next;
  assign ext  = (prefix_len_next > 3'd3) ||
                (!id_negative_next && (id_accum_next > cantx_pkg::STD_ID_MAX));
  assign eid_high = ext ? id[15:8] : held_eid_high;
  assign eid_low  = ext ? id[7:0]  : held_eid_low;

  always_comb begin
    frame.bytes = '0;
    if (ext) begin
      frame.bytes[0] = id[28:21];
      frame.bytes[1] = {id[20:18], 1'b0, 1'b1, 1'b0, id[17:16]};
    end else begin
      frame.bytes[0] = id[10:3];
      frame.bytes[1] = {id[2:0], 5'd0};
    end
    frame.bytes[2] = eid_high;
    frame.bytes[3] = eid_low;
    if (remote_flag_next) begin
      frame.bytes[4] = {4'd0, remote_len_next} | cantx_pkg::RTR_FLAG;
      frame.count    = 4'(cantx_pkg::HEADER_BYTES);
    end else begin
      frame.bytes[4] = {4'd0, data_count_next};
      frame.count    = 4'(cantx_pkg::HEADER_BYTES) + data_count_next;
    end
    for (int k = 0; k < cantx_pkg::MAX_DATA_BYTES; k++) begin
      frame.bytes[cantx_pkg::HEADER_BYTES + k] = data_next[k];
    end
  end

  assign frame_load = emit;

  // Parse state update; everything but the held EID bytes clears at line end.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEAD;
      id_accum      <= '0;
      id_negative   <= 1'b0;
      prefix_len    <= '0;
      pair_first    <= '0;
      pair_pending  <= 1'b0;
      data_count    <= '0;
      remote_flag   <= 1'b0;
      remote_len    <= '0;
      halted        <= 1'b0;
      held_eid_high <= '0;
      held_eid_low  <= '0;
    end else if (accept) begin
      if (line_end) begin
        phase        <= PH_LEAD;
        id_accum     <= '0;
        id_negative  <= 1'b0;
        prefix_len   <= '0;
        pair_first   <= '0;
        pair_pending <= 1'b0;
        data_count   <= '0;
        remote_flag  <= 1'b0;
        remote_len   <= '0;
        halted       <= 1'b0;
      end else begin
        phase        <= phase_next;
        id_accum     <= id_accum_next;
        id_negative  <= id_negative_next;
        prefix_len   <= prefix_len_next;
        pair_first   <= pair_first_next;
        pair_pending <= pair_pending_next;
        data_count   <= data_count_next;
        remote_flag  <= remote_flag_next;
        remote_len   <= remote_len_next;
        halted       <= halted_next;
      end
      if (emit && ext) begin
        held_eid_high <= id[15:8];
        held_eid_low  <= id[7:0];
      end
    end
  end

  // Data byte storage, written once per completed pair.
  always_ff @(posedge clk) begin
    if (accept && store_we) begin
      data_store[data_count[IDX_W-1:0]] <= store_byte;
    end
  end

endmodule

// ===== hw/rtl/cantx_emitter.sv =====
// Byte sender: holds one assembled frame and presents its bytes one per
// transaction on the output channel. Uses cantx_pkg.
module cantx_emitter (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  cantx_pkg::frame_t frame,
  output logic [7:0]        reg_byte,
  output logic [3:0]        byte_index,
  output logic              frame_last,
  output logic              byte_valid,
  input  logic              byte_ready
);

  logic [cantx_pkg::FRAME_BYTES-1:0][7:0] frame_buf;
  logic [3:0] remaining;
  logic [3:0] index;

  // Frame buffer shifts toward the output on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      index     <= '0;
    end else if (load) begin
      remaining <= frame.count;
      index     <= '0;
    end else if (byte_valid && byte_ready) begin
      remaining <= remaining - 4'd1;
      index     <= index + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_buf <= frame.bytes;
    end else if (byte_valid && byte_ready) begin
      frame_buf <= {8'd0, frame_buf[cantx_pkg::FRAME_BYTES-1:1]};
    end
  end

  assign byte_valid = (remaining != 4'd0);
  assign reg_byte   = frame_buf[0];
  assign byte_index = index;
  assign frame_last = (remaining == 4'd1);

endmodule
